// File: src/crc_framed_packet_receiver_defines.svh
// Assertion macros used by the receiver top level.
`ifndef CRC_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define CRC_FRAMED_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, reset disables the check.
`define CFPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfpr assertion failed");
// Next-cycle implication, reset disables the check.
`define CFPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfpr assertion failed");
`else
`define CFPR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFPR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/cfpr_pkg.sv
// Types, constants and the CRC byte update for the framed packet receiver.
`timescale 1ns / 1ps

package cfpr_pkg;

  // Frame geometry
  localparam int unsigned HeaderBytes   = 18;
  localparam int unsigned OverheadBytes = 20;
  localparam int unsigned MaxPayload    = 256;

  // Configuration register indexes
  localparam logic [2:0] RegSyncFirst  = 3'd0;
  localparam logic [2:0] RegSyncSecond = 3'd1;
  localparam logic [2:0] RegVersion    = 3'd2;
  localparam logic [2:0] RegLocalAddr  = 3'd3;
  localparam logic [2:0] RegCapacity   = 3'd4;

  // Result status codes
  localparam logic [2:0] StMore       = 3'd0;
  localparam logic [2:0] StOk         = 3'd1;
  localparam logic [2:0] StOther      = 3'd2;
  localparam logic [2:0] StCollectErr = 3'd3;
  localparam logic [2:0] StCheckErr   = 3'd4;

  // Header byte positions
  localparam logic [4:0] PosSync0    = 5'd0;
  localparam logic [4:0] PosVersion  = 5'd2;
  localparam logic [4:0] PosCommand  = 5'd3;
  localparam logic [4:0] PosFlags    = 5'd4;
  localparam logic [4:0] PosDest     = 5'd5;
  localparam logic [4:0] PosSource   = 5'd6;
  localparam logic [4:0] PosReserved = 5'd7;
  localparam logic [4:0] PosSession0 = 5'd8;
  localparam logic [4:0] PosSession1 = 5'd9;
  localparam logic [4:0] PosSession2 = 5'd10;
  localparam logic [4:0] PosSession3 = 5'd11;
  localparam logic [4:0] PosSeq0     = 5'd12;
  localparam logic [4:0] PosSeq1     = 5'd13;
  localparam logic [4:0] PosOffset0  = 5'd14;
  localparam logic [4:0] PosOffset1  = 5'd15;
  localparam logic [4:0] PosLength0  = 5'd16;
  localparam logic [4:0] PosLength1  = 5'd17;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // What the back end does with one byte
  typedef enum logic [2:0] {
    OpHunt,
    OpCapErr,
    OpResync,
    OpHeader,
    OpLenErr,
    OpPayload,
    OpCrcLow,
    OpCrcEnd
  } op_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] version_code;
    logic [7:0] local_address;
    logic [8:0] buffer_capacity;
  } cfg_t;

  // Classified byte travelling from front to back
  typedef struct packed {
    op_e        op;
    logic [4:0] hdr_pos;
    logic [7:0] pay_index;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        is_payload;
    logic [7:0]  payload_index;
    logic [7:0]  command;
    logic [7:0]  frame_flags;
    logic [7:0]  source_address;
    logic [31:0] session_number;
    logic [15:0] sequence_number;
    logic [15:0] image_offset;
    logic [8:0]  payload_length;
  } result_t;

  // CRC-16/MODBUS update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: src/crc_framed_packet_receiver.sv
// Top level of the sync-framed CRC-16 packet receiver.
//
//  channel  | handshake     | transfer when    | payload
//  ---------+---------------+------------------+----------------------------------
//  input    | push / full   | push && !full    | rx_byte_i
//  result   | empty / pop   | pop && !empty    | status_o .. payload_length_o
//  config   | cfg_we_i      | cfg_we_i         | cfg_index_i, cfg_wdata_i
//
// One byte per cycle while full stays low; each byte passes the queue, then the result register.
// The combinational CRC byte update in the back end sets the cycle budget.
// A two-entry queue lets the front keep taking bytes while a result waits.
// Reset is immediate: no clearing pass, the block takes bytes right after it.
`timescale 1ns / 1ps
`include "crc_framed_packet_receiver_defines.svh"

module crc_framed_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_wdata_i,
  // received bytes
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic        is_payload_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  command_o,
  output logic [7:0]  frame_flags_o,
  output logic [7:0]  source_address_o,
  output logic [31:0] session_number_o,
  output logic [15:0] sequence_number_o,
  output logic [15:0] image_offset_o,
  output logic [8:0]  payload_length_o
);

  cfpr_pkg::cfg_t    cfg_q;
  cfpr_pkg::item_t   fe_item, q_head;
  cfpr_pkg::result_t res;
  logic              fe_valid, q_full, q_head_valid, take, res_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first      <= 8'h55;
      cfg_q.sync_second     <= 8'hAA;
      cfg_q.version_code    <= 8'h01;
      cfg_q.local_address   <= 8'h00;
      cfg_q.buffer_capacity <= 9'd276;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfpr_pkg::RegSyncFirst:  cfg_q.sync_first      <= cfg_wdata_i[7:0];
        cfpr_pkg::RegSyncSecond: cfg_q.sync_second     <= cfg_wdata_i[7:0];
        cfpr_pkg::RegVersion:    cfg_q.version_code    <= cfg_wdata_i[7:0];
        cfpr_pkg::RegLocalAddr:  cfg_q.local_address   <= cfg_wdata_i[7:0];
        cfpr_pkg::RegCapacity:   cfg_q.buffer_capacity <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cfpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (push),
    .rx_byte_i    (rx_byte_i),
    .q_full_i     (q_full),
    .item_valid_o (fe_valid),
    .item_o       (fe_item)
  );

  cfpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (fe_valid),
    .wr_item_i    (fe_item),
    .full_o       (q_full),
    .rd_i         (take),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  cfpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_head_valid),
    .item_i       (q_head),
    .take_o       (take),
    .pop_i        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign full              = q_full;
  assign empty             = !res_valid;
  assign status_o          = res.status;
  assign data_byte_o       = res.data_byte;
  assign is_payload_o      = res.is_payload;
  assign payload_index_o   = res.payload_index;
  assign command_o         = res.command;
  assign frame_flags_o     = res.frame_flags;
  assign source_address_o  = res.source_address;
  assign session_number_o  = res.session_number;
  assign sequence_number_o = res.sequence_number;
  assign image_offset_o    = res.image_offset;
  assign payload_length_o  = res.payload_length;

  // Checks
  `CFPR_ASSERT_NXT(a_take_fills_result, clk_i, rst_ni, take, !empty)
  `CFPR_ASSERT_IMP(a_full_has_head, clk_i, rst_ni, full, q_head_valid)
  `CFPR_ASSERT_IMP(a_payload_is_more, clk_i, rst_ni, !empty && is_payload_o,
                   status_o == cfpr_pkg::StMore)
  `CFPR_ASSERT_IMP(a_header_only_ok, clk_i, rst_ni, !empty && status_o != cfpr_pkg::StOk,
                   session_number_o == 32'd0 && payload_length_o == 9'd0)

endmodule

// File: src/cfpr_front.sv
// Front end: tracks frame position and classifies each received byte.
`timescale 1ns / 1ps

module cfpr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfpr_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_full_i,
  output logic              item_valid_o,
  output cfpr_pkg::item_t   item_o
);

  logic [8:0]  pos_q, pos_d;
  logic [8:0]  exp_q, exp_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic        accept;
  logic [9:0]  pos_plus2;
  logic [15:0] len;
  logic [16:0] total;

  assign accept       = in_valid_i && !q_full_i;
  assign item_valid_o = accept;

  assign pos_plus2 = {1'b0, pos_q} + 10'd2;
  assign len       = {rx_byte_i, len_lo_q};
  assign total     = {1'b0, len} + 17'(cfpr_pkg::OverheadBytes);

  // Classification and position tracking
  always_comb begin
    pos_d    = pos_q;
    exp_d    = exp_q;
    len_lo_d = len_lo_q;
    item_o   = '0;
    item_o.data = rx_byte_i;
    item_o.op   = cfpr_pkg::OpHunt;

    if (cfg_i.buffer_capacity < 9'(cfpr_pkg::OverheadBytes)) begin
      item_o.op = cfpr_pkg::OpCapErr;
    end else if (pos_q == 9'd0 && rx_byte_i != cfg_i.sync_first) begin
      item_o.op = cfpr_pkg::OpHunt;
    end else if (pos_q == 9'd1 && rx_byte_i != cfg_i.sync_second) begin
      // bad second sync: a repeated first sync restarts the frame at it
      exp_d = '0;
      if (rx_byte_i == cfg_i.sync_first) begin
        item_o.op = cfpr_pkg::OpResync;
        pos_d     = 9'd1;
      end else begin
        item_o.op = cfpr_pkg::OpHunt;
        pos_d     = 9'd0;
      end
    end else if (pos_q >= cfg_i.buffer_capacity) begin
      item_o.op = cfpr_pkg::OpCapErr;
      pos_d     = '0;
      exp_d     = '0;
    end else begin
      pos_d = pos_q + 9'd1;
      if (exp_q != 9'd0 && pos_plus2 >= {1'b0, exp_q}) begin
        // trailer bytes: the low CRC byte, then the high byte that ends the frame
        pos_d = '0;
        exp_d = '0;
        if (pos_plus2 == {1'b0, exp_q}) item_o.op = cfpr_pkg::OpCrcLow;
        else                            item_o.op = cfpr_pkg::OpCrcEnd;
        if (pos_plus2 == {1'b0, exp_q}) begin
          pos_d = pos_q + 9'd1;
          exp_d = exp_q;
        end
      end else if (pos_q < 9'(cfpr_pkg::HeaderBytes)) begin
        item_o.op      = cfpr_pkg::OpHeader;
        item_o.hdr_pos = 5'(pos_q);
        if (5'(pos_q) == cfpr_pkg::PosLength0) len_lo_d = rx_byte_i;
        if (5'(pos_q) == cfpr_pkg::PosLength1) begin
          if (len > 16'(cfpr_pkg::MaxPayload) ||
              total > {8'h00, cfg_i.buffer_capacity}) begin
            item_o.op = cfpr_pkg::OpLenErr;
            pos_d     = '0;
            exp_d     = '0;
          end else begin
            exp_d = 9'(total);
          end
        end
      end else begin
        item_o.op        = cfpr_pkg::OpPayload;
        item_o.pay_index = 8'(pos_q - 9'(cfpr_pkg::HeaderBytes));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      exp_q    <= '0;
      len_lo_q <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      exp_q    <= exp_d;
      len_lo_q <= len_lo_d;
    end
  end

endmodule

// File: src/cfpr_queue.sv
// Two-entry queue of classified bytes between front and back end.
`timescale 1ns / 1ps

module cfpr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  cfpr_pkg::item_t  wr_item_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             head_valid_o,
  output cfpr_pkg::item_t  head_o
);

  localparam int unsigned Depth = cfpr_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cfpr_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = count_q == CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_item_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i)      count_q <= count_q + 1'b1;
      else if (rd_i && !wr_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

// File: src/cfpr_back.sv
// Back end: running CRC, header capture, frame verdict and result register.
`timescale 1ns / 1ps

module cfpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfpr_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  input  cfpr_pkg::item_t    item_i,
  output logic               take_o,
  input  logic               pop_i,
  output logic               res_valid_o,
  output cfpr_pkg::result_t  res_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic        fault_q, fault_d;
  logic [7:0]  held_cmd_q, held_cmd_d;
  logic [7:0]  held_flags_q, held_flags_d;
  logic [7:0]  held_dest_q, held_dest_d;
  logic [7:0]  held_src_q, held_src_d;
  logic [31:0] held_session_q, held_session_d;
  logic [15:0] held_seq_q, held_seq_d;
  logic [15:0] held_offset_q, held_offset_d;
  logic [8:0]  held_len_q, held_len_d;

  logic              res_valid_q;
  cfpr_pkg::result_t res_q, res_d;
  logic [15:0]       crc_base, crc_upd, crc_got;

  assign take_o      = item_valid_i && (!res_valid_q || pop_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign crc_base = (item_i.op == cfpr_pkg::OpResync ||
                     (item_i.op == cfpr_pkg::OpHeader && item_i.hdr_pos == cfpr_pkg::PosSync0))
                    ? cfpr_pkg::CrcInit : crc_q;
  assign crc_upd  = cfpr_pkg::crc_byte(crc_base, item_i.data);
  assign crc_got  = {item_i.data, crc_low_q};

  // Per-byte work
  always_comb begin
    crc_d          = crc_q;
    crc_low_d      = crc_low_q;
    fault_d        = fault_q;
    held_cmd_d     = held_cmd_q;
    held_flags_d   = held_flags_q;
    held_dest_d    = held_dest_q;
    held_src_d     = held_src_q;
    held_session_d = held_session_q;
    held_seq_d     = held_seq_q;
    held_offset_d  = held_offset_q;
    held_len_d     = held_len_q;
    res_d           = '0;
    res_d.data_byte = item_i.data;
    res_d.status    = cfpr_pkg::StMore;

    unique case (item_i.op)
      cfpr_pkg::OpHunt: begin
        res_d.status = cfpr_pkg::StMore;
      end
      cfpr_pkg::OpCapErr: begin
        res_d.status = cfpr_pkg::StCollectErr;
      end
      cfpr_pkg::OpResync: begin
        crc_d   = crc_upd;
        fault_d = 1'b0;
      end
      cfpr_pkg::OpHeader: begin
        crc_d = crc_upd;
        case (item_i.hdr_pos)
          cfpr_pkg::PosSync0:    fault_d = 1'b0;
          cfpr_pkg::PosVersion:  if (item_i.data != cfg_i.version_code) fault_d = 1'b1;
          cfpr_pkg::PosCommand:  held_cmd_d = item_i.data;
          cfpr_pkg::PosFlags:    held_flags_d = item_i.data;
          cfpr_pkg::PosDest:     held_dest_d = item_i.data;
          cfpr_pkg::PosSource:   held_src_d = item_i.data;
          cfpr_pkg::PosReserved: if (item_i.data != 8'h00) fault_d = 1'b1;
          cfpr_pkg::PosSession0: held_session_d = {24'h000000, item_i.data};
          cfpr_pkg::PosSession1: held_session_d[15:8] = item_i.data;
          cfpr_pkg::PosSession2: held_session_d[23:16] = item_i.data;
          cfpr_pkg::PosSession3: held_session_d[31:24] = item_i.data;
          cfpr_pkg::PosSeq0:     held_seq_d = {8'h00, item_i.data};
          cfpr_pkg::PosSeq1:     held_seq_d[15:8] = item_i.data;
          cfpr_pkg::PosOffset0:  held_offset_d = {8'h00, item_i.data};
          cfpr_pkg::PosOffset1:  held_offset_d[15:8] = item_i.data;
          cfpr_pkg::PosLength0:  held_len_d = {1'b0, item_i.data};
          cfpr_pkg::PosLength1:  held_len_d = {item_i.data[0], held_len_q[7:0]};
          default: ;
        endcase
      end
      cfpr_pkg::OpLenErr: begin
        crc_d        = crc_upd;
        res_d.status = cfpr_pkg::StCollectErr;
      end
      cfpr_pkg::OpPayload: begin
        crc_d               = crc_upd;
        res_d.is_payload    = 1'b1;
        res_d.payload_index = item_i.pay_index;
      end
      cfpr_pkg::OpCrcLow: begin
        crc_low_d = item_i.data;
      end
      cfpr_pkg::OpCrcEnd: begin
        // verdict: header or CRC fault first, then destination
        if (fault_q || crc_got != crc_q) begin
          res_d.status = cfpr_pkg::StCheckErr;
        end else if (held_dest_q != cfg_i.local_address) begin
          res_d.status = cfpr_pkg::StOther;
        end else begin
          res_d.status          = cfpr_pkg::StOk;
          res_d.command         = held_cmd_q;
          res_d.frame_flags     = held_flags_q;
          res_d.source_address  = held_src_q;
          res_d.session_number  = held_session_q;
          res_d.sequence_number = held_seq_q;
          res_d.image_offset    = held_offset_q;
          res_d.payload_length  = held_len_q;
        end
      end
    endcase
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q          <= cfpr_pkg::CrcInit;
      crc_low_q      <= '0;
      fault_q        <= 1'b0;
      held_cmd_q     <= '0;
      held_flags_q   <= '0;
      held_dest_q    <= '0;
      held_src_q     <= '0;
      held_session_q <= '0;
      held_seq_q     <= '0;
      held_offset_q  <= '0;
      held_len_q     <= '0;
    end else if (take_o) begin
      crc_q          <= crc_d;
      crc_low_q      <= crc_low_d;
      fault_q        <= fault_d;
      held_cmd_q     <= held_cmd_d;
      held_flags_q   <= held_flags_d;
      held_dest_q    <= held_dest_d;
      held_src_q     <= held_src_d;
      held_session_q <= held_session_d;
      held_seq_q     <= held_seq_d;
      held_offset_q  <= held_offset_d;
      held_len_q     <= held_len_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (take_o) begin
      res_valid_q <= 1'b1;
    end else if (pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) res_q <= res_d;
  end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the sync-framed CRC-16 packet receiver.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ReportLimit   = 10;

  // How a built frame is damaged
  typedef enum int {
    FlawNone,
    FlawVersion,
    FlawReserved,
    FlawCrc,
    FlawOverLength,
    FlawSecondSync
  } frame_flaw_e;

  // How header fields are filled
  typedef enum int {
    HdrRandom,
    HdrZeros,
    HdrOnes
  } hdr_fill_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [8:0]  cfg_wdata_i;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [7:0]  data_byte_o;
  logic        is_payload_o;
  logic [7:0]  payload_index_o;
  logic [7:0]  command_o;
  logic [7:0]  frame_flags_o;
  logic [7:0]  source_address_o;
  logic [31:0] session_number_o;
  logic [15:0] sequence_number_o;
  logic [15:0] image_offset_o;
  logic [8:0]  payload_length_o;

  crc_framed_packet_receiver u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .data_byte_o       (data_byte_o),
    .is_payload_o      (is_payload_o),
    .payload_index_o   (payload_index_o),
    .command_o         (command_o),
    .frame_flags_o     (frame_flags_o),
    .source_address_o  (source_address_o),
    .session_number_o  (session_number_o),
    .sequence_number_o (sequence_number_o),
    .image_offset_o    (image_offset_o),
    .payload_length_o  (payload_length_o)
  );

  // Receiver state mirror
  cfpr_pkg::cfg_t cfg;
  logic [8:0]  rx_pos;
  logic [8:0]  frame_total;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  logic        hdr_bad;
  logic [7:0]  h_cmd, h_flags, h_dest, h_src;
  logic [31:0] h_sess;
  logic [15:0] h_seq, h_off;
  logic [8:0]  h_len;

  cfpr_pkg::result_t verdict_q[$];
  logic [7:0]  frame_q[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned sent_count;
  int unsigned frame_count;
  int unsigned checked_count;
  int unsigned fail_cnt;
  int unsigned full_cycles;
  int unsigned quiet_run;
  int unsigned status_seen[8];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CRC-16/MODBUS, one bit at a time, LSB first
  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ cfpr_pkg::CrcPoly;
    end
    return c;
  endfunction

  task automatic mirror_reset();
    cfg.sync_first      = 8'h55;
    cfg.sync_second     = 8'hAA;
    cfg.version_code    = 8'h01;
    cfg.local_address   = 8'h00;
    cfg.buffer_capacity = 9'd276;
    rx_pos      = '0;
    frame_total = '0;
    crc_acc     = cfpr_pkg::CrcInit;
    crc_lo      = '0;
    hdr_bad     = 1'b0;
    h_cmd = '0; h_flags = '0; h_dest = '0; h_src = '0;
    h_sess = '0; h_seq = '0; h_off = '0; h_len = '0;
  endtask

  // Expected verdict for one received byte; advances the mirror
  function automatic cfpr_pkg::result_t predict_byte(input logic [7:0] b);
    cfpr_pkg::result_t r;
    int unsigned p;
    logic [15:0] len;
    logic [15:0] got;
    r = '0;
    r.status = cfpr_pkg::StMore;
    r.data_byte = b;
    if (cfg.buffer_capacity < cfpr_pkg::OverheadBytes) begin
      r.status = cfpr_pkg::StCollectErr;
      return r;
    end
    // sync hunt and second sync byte
    if (rx_pos == 0) begin
      if (b != cfg.sync_first) return r;
    end else if (rx_pos == 1 && b != cfg.sync_second) begin
      if (b == cfg.sync_first) begin
        rx_pos  = 9'd1;
        crc_acc = modbus_crc_next(cfpr_pkg::CrcInit, b);
        hdr_bad = 1'b0;
      end else begin
        rx_pos = '0;
      end
      frame_total = '0;
      return r;
    end
    if (rx_pos >= cfg.buffer_capacity) begin
      rx_pos = '0;
      frame_total = '0;
      r.status = cfpr_pkg::StCollectErr;
      return r;
    end
    p = rx_pos;
    rx_pos = rx_pos + 9'd1;
    if (p == 0) begin
      crc_acc = cfpr_pkg::CrcInit;
      hdr_bad = 1'b0;
    end
    // trailing CRC bytes
    if (frame_total != 0 && p + 2 >= frame_total) begin
      if (p + 2 == frame_total) begin
        crc_lo = b;
      end else begin
        got = {b, crc_lo};
        rx_pos = '0;
        frame_total = '0;
        if (hdr_bad || got != crc_acc) begin
          r.status = cfpr_pkg::StCheckErr;
        end else if (h_dest != cfg.local_address) begin
          r.status = cfpr_pkg::StOther;
        end else begin
          r.status          = cfpr_pkg::StOk;
          r.command         = h_cmd;
          r.frame_flags     = h_flags;
          r.source_address  = h_src;
          r.session_number  = h_sess;
          r.sequence_number = h_seq;
          r.image_offset    = h_off;
          r.payload_length  = h_len;
        end
      end
      return r;
    end
    crc_acc = modbus_crc_next(crc_acc, b);
    // header fields and payload
    case (p)
      cfpr_pkg::PosVersion:  if (b != cfg.version_code) hdr_bad = 1'b1;
      cfpr_pkg::PosCommand:  h_cmd = b;
      cfpr_pkg::PosFlags:    h_flags = b;
      cfpr_pkg::PosDest:     h_dest = b;
      cfpr_pkg::PosSource:   h_src = b;
      cfpr_pkg::PosReserved: if (b != 8'h00) hdr_bad = 1'b1;
      cfpr_pkg::PosSession0: h_sess = {24'h0, b};
      cfpr_pkg::PosSession1: h_sess[15:8] = b;
      cfpr_pkg::PosSession2: h_sess[23:16] = b;
      cfpr_pkg::PosSession3: h_sess[31:24] = b;
      cfpr_pkg::PosSeq0:     h_seq = {8'h0, b};
      cfpr_pkg::PosSeq1:     h_seq[15:8] = b;
      cfpr_pkg::PosOffset0:  h_off = {8'h0, b};
      cfpr_pkg::PosOffset1:  h_off[15:8] = b;
      cfpr_pkg::PosLength0:  h_len = {1'b0, b};
      cfpr_pkg::PosLength1: begin
        len = {b, h_len[7:0]};
        if (len > cfpr_pkg::MaxPayload ||
            cfpr_pkg::OverheadBytes + len > cfg.buffer_capacity) begin
          rx_pos = '0;
          frame_total = '0;
          r.status = cfpr_pkg::StCollectErr;
          return r;
        end
        h_len = len[8:0];
        frame_total = len[8:0] + 9'(cfpr_pkg::OverheadBytes);
      end
      default: begin
        if (p >= cfpr_pkg::HeaderBytes) begin
          r.is_payload = 1'b1;
          r.payload_index = 8'(p - cfpr_pkg::HeaderBytes);
        end
      end
    endcase
    return r;
  endfunction

  // Offer one byte; record its verdict once it transfers
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    rx_byte_i = b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    verdict_q.push_back(predict_byte(b));
    sent_count++;
  endtask

  // Stop offering and wait until every verdict has come out
  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      cfpr_pkg::RegSyncFirst:  cfg.sync_first = val[7:0];
      cfpr_pkg::RegSyncSecond: cfg.sync_second = val[7:0];
      cfpr_pkg::RegVersion:    cfg.version_code = val[7:0];
      cfpr_pkg::RegLocalAddr:  cfg.local_address = val[7:0];
      cfpr_pkg::RegCapacity:   cfg.buffer_capacity = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] fill_byte(input hdr_fill_e fill);
    case (fill)
      HdrZeros: return 8'h00;
      HdrOnes:  return 8'hFF;
      default:  return 8'($urandom_range(255));
    endcase
  endfunction

  // Assemble one frame in frame_q under the current settings
  task automatic build_frame(input logic [7:0] dest, input int unsigned len,
                             input frame_flaw_e flaw, input hdr_fill_e fill);
    logic [15:0] len_field;
    logic [15:0] c;
    logic [7:0]  v;
    frame_q.delete();
    frame_count++;
    if (flaw == FlawOverLength)
      len_field = 16'($urandom_range(65535, cfpr_pkg::MaxPayload + 1));
    else len_field = 16'(len);
    frame_q.push_back(cfg.sync_first);
    v = cfg.sync_second;
    if (flaw == FlawSecondSync) begin
      while (v == cfg.sync_second || v == cfg.sync_first) v = 8'($urandom_range(255));
    end
    frame_q.push_back(v);
    v = cfg.version_code;
    if (flaw == FlawVersion) v = cfg.version_code ^ 8'($urandom_range(255, 1));
    frame_q.push_back(v);
    frame_q.push_back(fill_byte(fill));
    frame_q.push_back(fill_byte(fill));
    frame_q.push_back(dest);
    frame_q.push_back(fill_byte(fill));
    v = 8'h00;
    if (flaw == FlawReserved) v = 8'($urandom_range(255, 1));
    frame_q.push_back(v);
    for (int i = 0; i < 8; i++) frame_q.push_back(fill_byte(fill));
    frame_q.push_back(len_field[7:0]);
    frame_q.push_back(len_field[15:8]);
    // over-length frames are cut at the length field
    if (flaw != FlawOverLength) begin
      for (int i = 0; i < len; i++) begin
        v = 8'($urandom_range(255));
        frame_q.push_back(v);
      end
      c = cfpr_pkg::CrcInit;
      foreach (frame_q[i]) c = modbus_crc_next(c, frame_q[i]);
      if (flaw == FlawCrc) c = c ^ (16'h0001 << $urandom_range(15));
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
    end
  endtask

  task automatic send_frame(input logic [7:0] dest, input int unsigned len,
                            input frame_flaw_e flaw, input hdr_fill_e fill);
    build_frame(dest, len, flaw, fill);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Stray bytes, biased toward the sync values
  task automatic send_noise(input int unsigned n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0: v = cfg.sync_first;
        1: v = cfg.sync_second;
        default: v = 8'($urandom_range(255));
      endcase
      send_byte(v);
    end
  endtask

  // Basic verdicts and flaws under reset settings, and frame totals against a lowered capacity
  task automatic test_directed_frames();
    idle_pct = 0;
    stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_frame(cfg.local_address, 0, FlawNone, HdrZeros);
    send_frame(cfg.local_address, 1, FlawNone, HdrOnes);
    send_frame(cfg.local_address, cfpr_pkg::MaxPayload, FlawNone, HdrRandom);
    send_frame(8'h3C, 2, FlawNone, HdrRandom);
    send_frame(cfg.local_address, 2, FlawVersion, HdrRandom);
    send_frame(cfg.local_address, 2, FlawReserved, HdrRandom);
    send_frame(cfg.local_address, 2, FlawCrc, HdrRandom);
    send_frame(cfg.local_address, 2, FlawOverLength, HdrRandom);
    send_frame(cfg.local_address, 2, FlawSecondSync, HdrRandom);
    // repeated first sync byte resynchronizes
    send_byte(cfg.sync_first);
    send_frame(cfg.local_address, 1, FlawNone, HdrRandom);
    // total against capacity
    write_reg(cfpr_pkg::RegCapacity, 9'd40);
    send_frame(cfg.local_address, 21, FlawNone, HdrRandom);
    send_frame(cfg.local_address, 20, FlawNone, HdrRandom);
    write_reg(cfpr_pkg::RegCapacity, 9'd276);
    drain();
  endtask

  // Register extremes and settings changed in the middle of a frame
  task automatic test_register_extremes();
    write_reg(cfpr_pkg::RegSyncFirst, 9'h000);
    write_reg(cfpr_pkg::RegSyncSecond, 9'h0FF);
    write_reg(cfpr_pkg::RegVersion, 9'h1FF);
    write_reg(cfpr_pkg::RegLocalAddr, 9'h0FF);
    send_frame(8'hFF, 3, FlawNone, HdrRandom);
    send_frame(8'h00, 1, FlawNone, HdrOnes);
    write_reg(cfpr_pkg::RegSyncFirst, 9'h1FF);
    write_reg(cfpr_pkg::RegSyncSecond, 9'h100);
    write_reg(cfpr_pkg::RegVersion, 9'h000);
    write_reg(cfpr_pkg::RegLocalAddr, 9'h000);
    send_frame(8'h00, 2, FlawNone, HdrZeros);
    send_noise(4);
    write_reg(cfpr_pkg::RegSyncFirst, 9'h055);
    write_reg(cfpr_pkg::RegSyncSecond, 9'h0AA);
    write_reg(cfpr_pkg::RegVersion, 9'h001);
    // small capacity freezes the frame in progress
    build_frame(cfg.local_address, 3, FlawNone, HdrRandom);
    for (int i = 0; i < 10; i++) send_byte(frame_q[i]);
    write_reg(cfpr_pkg::RegCapacity, 9'd19);
    send_noise(3);
    write_reg(cfpr_pkg::RegCapacity, 9'd276);
    for (int i = 10; i < frame_q.size(); i++) send_byte(frame_q[i]);
    write_reg(cfpr_pkg::RegCapacity, 9'd0);
    send_frame(cfg.local_address, 0, FlawNone, HdrRandom);
    write_reg(cfpr_pkg::RegCapacity, 9'd20);
    send_frame(cfg.local_address, 0, FlawNone, HdrRandom);
    send_frame(cfg.local_address, 1, FlawNone, HdrRandom);
    // capacity lowered under the current position
    write_reg(cfpr_pkg::RegCapacity, 9'd276);
    build_frame(cfg.local_address, 50, FlawNone, HdrRandom);
    for (int i = 0; i < 30; i++) send_byte(frame_q[i]);
    write_reg(cfpr_pkg::RegCapacity, 9'd25);
    for (int i = 30; i < frame_q.size(); i++) send_byte(frame_q[i]);
    // version is judged when its byte arrives
    write_reg(cfpr_pkg::RegCapacity, 9'd276);
    build_frame(cfg.local_address, 2, FlawNone, HdrRandom);
    for (int i = 0; i < 3; i++) send_byte(frame_q[i]);
    write_reg(cfpr_pkg::RegVersion, 9'h002);
    for (int i = 3; i < frame_q.size(); i++) send_byte(frame_q[i]);
    write_reg(cfpr_pkg::RegVersion, 9'h001);
    drain();
  endtask

  // Mostly clean frames, some damaged, some stray bytes
  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned nbytes);
    int unsigned start;
    int unsigned len;
    int unsigned k;
    logic [8:0]  capv;
    logic [7:0]  dest;
    frame_flaw_e flaw;
    write_reg(cfpr_pkg::RegSyncFirst, 9'($urandom_range(511)));
    write_reg(cfpr_pkg::RegSyncSecond, 9'($urandom_range(511)));
    write_reg(cfpr_pkg::RegVersion, 9'($urandom_range(511)));
    write_reg(cfpr_pkg::RegLocalAddr, 9'($urandom_range(511)));
    capv = 9'd276;
    if ($urandom_range(99) < 40) capv = 9'($urandom_range(276, 20));
    write_reg(cfpr_pkg::RegCapacity, capv);
    idle_pct = idle;
    stall_pct = stall;
    start = sent_count;
    while (sent_count - start < nbytes) begin
      if ($urandom_range(9) == 0) len = $urandom_range(cfpr_pkg::MaxPayload);
      else len = $urandom_range(12);
      if (len + cfpr_pkg::OverheadBytes > cfg.buffer_capacity && $urandom_range(3) != 0)
        len = cfg.buffer_capacity - cfpr_pkg::OverheadBytes;
      k = $urandom_range(99);
      dest = cfg.local_address;
      flaw = FlawNone;
      if (k >= 60 && k < 68) dest = 8'($urandom_range(255));
      if (k >= 68 && k < 88) begin
        case ($urandom_range(4))
          0: flaw = FlawVersion;
          1: flaw = FlawReserved;
          2: flaw = FlawCrc;
          3: flaw = FlawOverLength;
          default: flaw = FlawSecondSync;
        endcase
      end
      if (k >= 88) send_noise($urandom_range(6, 1));
      else send_frame(dest, len, flaw, HdrRandom);
    end
    drain();
  endtask

  // Results held back long enough that the input side stalls
  task automatic test_input_backpressure();
    int unsigned start;
    write_reg(cfpr_pkg::RegCapacity, 9'd276);
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    start = sent_count;
    while (sent_count - start < 110)
      send_frame(cfg.local_address, $urandom_range(8), FlawNone, HdrRandom);
    drain();
  endtask

  // Result side: random stalls, plus a counted hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each transferred result with the oldest pending verdict
  cfpr_pkg::result_t seen;
  cfpr_pkg::result_t want;
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      seen.status          = status_o;
      seen.data_byte       = data_byte_o;
      seen.is_payload      = is_payload_o;
      seen.payload_index   = payload_index_o;
      seen.command         = command_o;
      seen.frame_flags     = frame_flags_o;
      seen.source_address  = source_address_o;
      seen.session_number  = session_number_o;
      seen.sequence_number = sequence_number_o;
      seen.image_offset    = image_offset_o;
      seen.payload_length  = payload_length_o;
      if (verdict_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ReportLimit)
          $display("Unexpected result: status %0d data %02h", seen.status, seen.data_byte);
      end else begin
        want = verdict_q.pop_front();
        checked_count++;
        status_seen[seen.status]++;
        if (seen !== want) begin
          fail_cnt++;
          if (fail_cnt <= ReportLimit) begin
            $display("Mismatch on byte %02h: exp st %0d pay %0b idx %0d",
                     want.data_byte, want.status, want.is_payload, want.payload_index);
            $display("  got st %0d pay %0b idx %0d data %02h",
                     seen.status, seen.is_payload, seen.payload_index, seen.data_byte);
            $display("  exp hdr %02h %02h %02h %08h %04h %04h %03h",
                     want.command, want.frame_flags, want.source_address,
                     want.session_number, want.sequence_number, want.image_offset,
                     want.payload_length);
            $display("  got hdr %02h %02h %02h %08h %04h %04h %03h",
                     seen.command, seen.frame_flags, seen.source_address,
                     seen.session_number, seen.sequence_number, seen.image_offset,
                     seen.payload_length);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) full_cycles++;
      if ((push && !full) || (pop && !empty)) quiet_run = 0;
      else quiet_run++;
      if (quiet_run >= WatchdogLimit) begin
        $display("Timeout: no transfer for %0d cycles, %0d verdicts pending",
                 quiet_run, verdict_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Sequence of tests
  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    rx_byte_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = cfpr_pkg::RegSyncFirst;
    cfg_wdata_i = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_left   = 0;
    sent_count  = 0;
    frame_count = 0;
    checked_count = 0;
    fail_cnt    = 0;
    full_cycles = 0;
    quiet_run   = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    mirror_reset();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_frames();
    test_register_extremes();
    test_random_traffic(0, 0, 40);
    test_random_traffic(54, 0, 40);
    test_random_traffic(0, 54, 40);
    test_random_traffic(35, 35, 40);
    test_input_backpressure();
    drain();
    repeat (6) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0d verdicts never arrived", verdict_q.size());
      fail_cnt += verdict_q.size();
    end

    $display("Checked %0d results from %0d bytes in %0d frames",
             checked_count, sent_count, frame_count);
    $display("  ok %0d, other %0d, check err %0d, collect err %0d",
             status_seen[cfpr_pkg::StOk], status_seen[cfpr_pkg::StOther],
             status_seen[cfpr_pkg::StCheckErr], status_seen[cfpr_pkg::StCollectErr]);
    $display("Swept sync, version, address and capacity settings; input held off %0d cycles",
             full_cycles);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
